// ===== rtl/core/spq_pkg.sv =====
// Shared constants and control types for the stable priority queue.
// Used by spq_ctrl, spq_datapath and stable_priority_queue; no dependencies.
package spq_pkg;

  // Default sizes handed to the top-level parameters
  localparam int DEF_QUEUE_DEPTH   = 16;
  localparam int DEF_ID_BITS       = 8;
  localparam int DEF_PRIORITY_BITS = 8;

  // Occupancy field is fixed at five bits, carrying the low bits of the count
  localparam int OCC_BITS = 5;

  // Command codes on the input word
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture a result word this cycle
    logic ins;     // insert the incoming entry into the cell array
    logic rem;     // pop the head cell
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;
    logic full;
  } dp_status_t;

endpackage

// ===== rtl/core/spq_ctrl.sv =====
// Handshake controller for the stable priority queue.
// Depends on spq_pkg; drives dp_cmd_t to spq_datapath and reads dp_status_t.
module spq_ctrl
  import spq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_cmd,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic ST_IDLE = 1'b0;  // no result word waiting
  localparam logic ST_HOLD = 1'b1;  // result word held in the output register

  logic state_r;
  logic state_nxt;
  logic accept;

  // Stall the input only while a held result is itself stalled
  assign in_stall  = (state_r == ST_HOLD) && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = (state_r == ST_HOLD);

  // Decode the accepted word into datapath commands
  always_comb begin
    cmd.load = accept;
    cmd.ins  = accept && (in_cmd == CMD_INSERT) && !status.full;
    cmd.rem  = accept && (in_cmd == CMD_REMOVE) && !status.empty;
  end

  // Advance the output-register state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (accept) state_nxt = ST_HOLD;
        else if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/spq_datapath.sv =====
// Sorted shift-register cell array and result register of the priority queue.
// Depends on spq_pkg; commanded by spq_ctrl.
module spq_datapath
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
  parameter int ID_BITS       = DEF_ID_BITS,
  parameter int PRIORITY_BITS = DEF_PRIORITY_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  cmd,
  output dp_status_t               status,
  input  logic [ID_BITS-1:0]       in_entry_id,
  input  logic [PRIORITY_BITS-1:0] in_entry_priority,
  output logic [ID_BITS-1:0]       out_removed_id,
  output logic                     out_removed_valid,
  output logic                     out_insert_accepted,
  output logic [OCC_BITS-1:0]      out_occupancy
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [ID_BITS-1:0]       id_r   [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] prio_r [QUEUE_DEPTH];
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic [QUEUE_DEPTH-1:0]   stays;   // cell is valid and ranks ahead of the new entry

  logic [ID_BITS-1:0]  removed_id_r;
  logic                removed_valid_r;
  logic                insert_accepted_r;
  logic [OCC_BITS-1:0] occupancy_r;

  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == CNT_W'(QUEUE_DEPTH));

  // Per-cell compare and shift; equal priority stays ahead for arrival order
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign stays[i] = (CNT_W'(i) < count_r) && (prio_r[i] <= in_entry_priority);

    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (cmd.ins) begin
          if (!stays[0]) begin
            id_r[0]   <= in_entry_id;
            prio_r[0] <= in_entry_priority;
          end
        end else if (cmd.rem && QUEUE_DEPTH > 1) begin
          id_r[0]   <= id_r[1];
          prio_r[0] <= prio_r[1];
        end
      end
    end else if (i == QUEUE_DEPTH - 1) begin : g_tail
      always_ff @(posedge clk) begin
        if (cmd.ins && !stays[i]) begin
          if (stays[i-1]) begin
            id_r[i]   <= in_entry_id;
            prio_r[i] <= in_entry_priority;
          end else begin
            id_r[i]   <= id_r[i-1];
            prio_r[i] <= prio_r[i-1];
          end
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (cmd.ins) begin
          if (!stays[i]) begin
            if (stays[i-1]) begin
              id_r[i]   <= in_entry_id;
              prio_r[i] <= in_entry_priority;
            end else begin
              id_r[i]   <= id_r[i-1];
              prio_r[i] <= prio_r[i-1];
            end
          end
        end else if (cmd.rem) begin
          id_r[i]   <= id_r[i+1];
          prio_r[i] <= prio_r[i+1];
        end
      end
    end
  end

  // Track occupancy
  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) count_nxt = count_r + CNT_W'(1);
    else if (cmd.rem) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Capture the result word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      removed_id_r      <= cmd.rem ? id_r[0] : '0;
      removed_valid_r   <= cmd.rem;
      insert_accepted_r <= cmd.ins;
      occupancy_r       <= OCC_BITS'(count_nxt);
    end
  end

  assign out_removed_id      = removed_id_r;
  assign out_removed_valid   = removed_valid_r;
  assign out_insert_accepted = insert_accepted_r;
  assign out_occupancy       = occupancy_r;

endmodule

// ===== rtl/core/stable_priority_queue.sv =====
// Stable priority queue: bounded, sorted by priority, arrival order on ties.
// Input word: in_cmd (insert or remove), in_entry_id, in_entry_priority.
// Result word: out_removed_id, out_removed_valid, out_insert_accepted and
// out_occupancy, the entry count after the step (low five bits).
// Every accepted input word gives exactly one result word, in order.
// A word is taken when valid is high and stall low. Insert places the entry
// behind all stored entries of lower or equal priority number; remove pops
// the head. Remove on empty and insert on full leave the queue unchanged.
// The result word is loaded into the output register at the accepting edge
// and is offered in the following cycle. Throughput is one word per cycle
// while the receiver does not stall, set by the cell array, where every cell
// compares against the new priority in parallel and shifts by one position.
// When the receiver stalls, the held result word stays put and the input
// is stalled in turn; a word is accepted again once the result is taken.
// Synchronous active-low reset empties the queue and drops any held result;
// no clearing pass is needed, so words are accepted right after reset.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
  parameter int ID_BITS       = DEF_ID_BITS,
  parameter int PRIORITY_BITS = DEF_PRIORITY_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_cmd,
  input  logic [ID_BITS-1:0]       in_entry_id,
  input  logic [PRIORITY_BITS-1:0] in_entry_priority,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [ID_BITS-1:0]       out_removed_id,
  output logic                     out_removed_valid,
  output logic                     out_insert_accepted,
  output logic [OCC_BITS-1:0]      out_occupancy
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Controller: handshake and command decode
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: sorted cell array and result register
  spq_datapath #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .ID_BITS       (ID_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_entry_id         (in_entry_id),
    .in_entry_priority   (in_entry_priority),
    .out_removed_id      (out_removed_id),
    .out_removed_valid   (out_removed_valid),
    .out_insert_accepted (out_insert_accepted),
    .out_occupancy       (out_occupancy)
  );

endmodule
